### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the load/store sequencer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hdl/lsts_pkg.sv
// ----------------------------------------------------------------------------
// Load/store sequencer package
// Shared codes, widths and control structures for the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsts_pkg;

	localparam int REGISTER_COUNT = 16;
	localparam int REG_INDEX_W    = $clog2(REGISTER_COUNT);
	localparam int WORD_W         = 32;

	localparam logic [2:0] TYPE_SINGLE_IMM = 3'b010;
	localparam logic [2:0] TYPE_SINGLE_REG = 3'b011;
	localparam logic [2:0] TYPE_MULTIPLE   = 3'b100;

	localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

	localparam logic ITEM_XFER = 1'b0;
	localparam logic ITEM_DONE = 1'b1;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_COND_FAILED = 2'd1;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

	localparam logic [1:0] SHIFT_LSL = 2'd0;
	localparam logic [1:0] SHIFT_LSR = 2'd1;
	localparam logic [1:0] SHIFT_ASR = 2'd2;
	localparam logic [1:0] SHIFT_ROR = 2'd3;

	typedef enum logic [1:0] {
		MODE_FAIL   = 2'd0,
		MODE_UNSUP  = 2'd1,
		MODE_SINGLE = 2'd2,
		MODE_MULTI  = 2'd3
	} mode_t;

	typedef struct packed {
		logic capture;
		logic calc_offset;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic in_single;
		logic can_emit;
		logic last_item;
	} dp_status_t;

endpackage

`default_nettype wire

### hdl/lsts_cmd_if.sv
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one load/store instruction with operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsts_cmd_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic        condition_passed;
	logic [31:0] base_value;
	logic [31:0] offset_register_value;
	logic        carry_in;

	modport source (
		output valid, instruction, condition_passed, base_value,
		       offset_register_value, carry_in,
		input  ready
	);

	modport sink (
		input  valid, instruction, condition_passed, base_value,
		       offset_register_value, carry_in,
		output ready
	);
endinterface

`default_nettype wire

### hdl/lsts_xfer_if.sv
// ----------------------------------------------------------------------------
// Transfer channel
// Valid/ready channel that carries transfer commands and completion beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsts_xfer_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic        is_load;
	logic        is_byte;
	logic [31:0] address;
	logic [3:0]  register_index;
	logic        writeback_enable;
	logic [1:0]  status;
	logic        final_item;

	modport source (
		output valid, item_kind, is_load, is_byte, address, register_index,
		       writeback_enable, status, final_item,
		input  ready
	);

	modport sink (
		input  valid, item_kind, is_load, is_byte, address, register_index,
		       writeback_enable, status, final_item,
		output ready
	);
endinterface

`default_nettype wire

### hdl/lsts_datapath.sv
// ----------------------------------------------------------------------------
// Sequencer datapath
// Holds the decoded instruction, offset, address and pending register list,
// and builds each output beat into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsts_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lsts_pkg::dp_cmd_t   cmd,
	output lsts_pkg::dp_status_t stat,
	input  logic [31:0]         instruction,
	input  logic                condition_passed,
	input  logic [31:0]         base_value,
	input  logic [31:0]         offset_register_value,
	input  logic                carry_in,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                item_kind,
	output logic                is_load,
	output logic                is_byte,
	output logic [31:0]         address,
	output logic [3:0]          register_index,
	output logic                writeback_enable,
	output logic [1:0]          status,
	output logic                final_item
);

	localparam int RC = lsts_pkg::REGISTER_COUNT;
	localparam int IW = lsts_pkg::REG_INDEX_W;
	localparam int WW = lsts_pkg::WORD_W;

	logic [2:0]          ins_type;
	lsts_pkg::mode_t     mode_in;
	logic [RC-1:0]       list_rev;

	lsts_pkg::mode_t     mode_q;
	logic                ibit_q;
	logic                u_q;
	logic                b_q;
	logic                w_q;
	logic                l_q;
	logic [IW-1:0]       rn_q;
	logic [IW-1:0]       rd_q;
	logic [11:0]         spec_q;
	logic [WW-1:0]       rm_q;
	logic                carry_q;
	logic [WW-1:0]       addr_q;
	logic [WW-1:0]       off_q;
	logic [RC-1:0]       mask_q;
	logic                phase_q;

	logic [4:0]          amt;
	logic [1:0]          shift_kind;
	logic [2*WW-1:0]     rot_wide;
	logic [WW-1:0]       scaled;
	logic [WW-1:0]       ea;
	logic [WW-1:0]       addr_dec;
	logic [IW-1:0]       pick;
	logic [IW-1:0]       pick_reg;

	logic                nx_kind;
	logic                nx_load;
	logic                nx_byte;
	logic [WW-1:0]       nx_addr;
	logic [IW-1:0]       nx_reg;
	logic                nx_wb;
	logic [1:0]          nx_status;
	logic                nx_final;

	logic                out_valid_q;
	logic                item_kind_q;
	logic                is_load_q;
	logic                is_byte_q;
	logic [WW-1:0]       address_q;
	logic [IW-1:0]       register_index_q;
	logic                writeback_enable_q;
	logic [1:0]          status_q;
	logic                final_item_q;

	// Incoming instruction classification.
	always_comb begin
		ins_type = instruction[27:25];
		if (!condition_passed) begin
			mode_in = lsts_pkg::MODE_FAIL;
		end else if (ins_type == lsts_pkg::TYPE_SINGLE_IMM ||
		             ins_type == lsts_pkg::TYPE_SINGLE_REG) begin
			if (!instruction[24] || (instruction[25] && instruction[4])) begin
				mode_in = lsts_pkg::MODE_UNSUP;
			end else begin
				mode_in = lsts_pkg::MODE_SINGLE;
			end
		end else if (ins_type == lsts_pkg::TYPE_MULTIPLE) begin
			mode_in = lsts_pkg::MODE_MULTI;
		end else begin
			mode_in = lsts_pkg::MODE_UNSUP;
		end
	end

	// Stores walk the list highest first, so their list is kept reversed.
	always_comb begin
		for (int i = 0; i < RC; i++) begin
			list_rev[i] = instruction[RC-1-i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode_in;
			ibit_q  <= instruction[25];
			u_q     <= instruction[23];
			b_q     <= instruction[22];
			w_q     <= instruction[21];
			l_q     <= instruction[20];
			rn_q    <= instruction[19:16];
			rd_q    <= instruction[15:12];
			spec_q  <= instruction[11:0];
			rm_q    <= offset_register_value;
			carry_q <= carry_in;
			addr_q  <= base_value;
			mask_q  <= instruction[20] ? instruction[RC-1:0] : list_rev;
			phase_q <= 1'b0;
		end else begin
			if (cmd.calc_offset) begin
				off_q <= ibit_q ? scaled : {{(WW-12){1'b0}}, spec_q};
			end
			if (cmd.emit) begin
				unique case (mode_q)
					lsts_pkg::MODE_SINGLE: begin
						phase_q <= 1'b1;
						if (!phase_q) begin
							addr_q <= ea;
						end
					end
					lsts_pkg::MODE_MULTI: begin
						if (mask_q != '0) begin
							mask_q <= mask_q & (mask_q - {{(RC-1){1'b0}}, 1'b1});
							addr_q <= l_q ? addr_q + lsts_pkg::WORD_STEP : addr_dec;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Scaled register offset.
	always_comb begin
		amt        = spec_q[11:7];
		shift_kind = spec_q[6:5];
		rot_wide   = {rm_q, rm_q} >> amt;
		case (shift_kind)
			lsts_pkg::SHIFT_LSL: scaled = rm_q << amt;
			lsts_pkg::SHIFT_LSR: scaled = (amt == '0) ? '0 : rm_q >> amt;
			lsts_pkg::SHIFT_ASR: scaled = (amt == '0) ? {WW{rm_q[WW-1]}} :
			                              WW'($signed(rm_q) >>> amt);
			default: scaled = (amt == '0) ? {carry_q, rm_q[WW-1:1]} : rot_wide[WW-1:0];
		endcase
	end

	assign ea       = u_q ? addr_q + off_q : addr_q - off_q;
	assign addr_dec = addr_q - lsts_pkg::WORD_STEP;

	// Lowest pending bit of the list.
	always_comb begin
		pick = '0;
		for (int i = RC - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = IW'(i);
			end
		end
	end

	assign pick_reg = l_q ? pick : ~pick;

	// Next beat.
	always_comb begin
		nx_kind   = lsts_pkg::ITEM_DONE;
		nx_load   = 1'b0;
		nx_byte   = 1'b0;
		nx_addr   = '0;
		nx_reg    = '0;
		nx_wb     = 1'b0;
		nx_status = lsts_pkg::STATUS_OK;
		nx_final  = 1'b1;
		unique case (mode_q)
			lsts_pkg::MODE_FAIL: begin
				nx_status = lsts_pkg::STATUS_COND_FAILED;
			end
			lsts_pkg::MODE_UNSUP: begin
				nx_status = lsts_pkg::STATUS_UNSUPPORTED;
			end
			lsts_pkg::MODE_SINGLE: begin
				nx_load = l_q;
				nx_byte = b_q;
				if (!phase_q) begin
					nx_kind  = lsts_pkg::ITEM_XFER;
					nx_addr  = ea;
					nx_reg   = rd_q;
					nx_final = 1'b0;
				end else begin
					nx_addr = addr_q;
					nx_reg  = rn_q;
					nx_wb   = w_q;
				end
			end
			default: begin
				nx_load = l_q;
				if (mask_q != '0) begin
					nx_kind  = lsts_pkg::ITEM_XFER;
					nx_addr  = l_q ? addr_q : addr_dec;
					nx_reg   = pick_reg;
					nx_final = 1'b0;
				end else begin
					nx_addr = addr_q;
					nx_reg  = rn_q;
					nx_wb   = w_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			item_kind_q        <= nx_kind;
			is_load_q          <= nx_load;
			is_byte_q          <= nx_byte;
			address_q          <= nx_addr;
			register_index_q   <= nx_reg;
			writeback_enable_q <= nx_wb;
			status_q           <= nx_status;
			final_item_q       <= nx_final;
		end
	end

	assign stat.in_single = (mode_in == lsts_pkg::MODE_SINGLE);
	assign stat.can_emit  = !out_valid_q || out_ready;
	assign stat.last_item = nx_final;

	assign out_valid        = out_valid_q;
	assign item_kind        = item_kind_q;
	assign is_load          = is_load_q;
	assign is_byte          = is_byte_q;
	assign address          = address_q;
	assign register_index   = register_index_q;
	assign writeback_enable = writeback_enable_q;
	assign status           = status_q;
	assign final_item       = final_item_q;

endmodule

`default_nettype wire

### hdl/lsts_controller.sv
// ----------------------------------------------------------------------------
// Sequencer controller
// State machine that accepts an instruction, prepares the offset of a single
// transfer, and steps the datapath through its beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsts_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lsts_pkg::dp_status_t stat,
	output lsts_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_OFFSET = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx        = state_q;
		cmd.capture     = 1'b0;
		cmd.calc_offset = 1'b0;
		cmd.emit        = 1'b0;
		in_ready        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = stat.in_single ? ST_OFFSET : ST_EMIT;
				end
			end
			ST_OFFSET: begin
				cmd.calc_offset = 1'b1;
				state_nx        = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.can_emit) begin
					cmd.emit = 1'b1;
					if (stat.last_item) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

### hdl/load_store_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// Load/store transfer sequencer
// Turns one load/store instruction into a run of transfer beats that ends
// in a completion beat carrying the base writeback value.
//
// The cmd channel takes one instruction word with its base and offset
// register values, the condition result and the carry flag. The xfer
// channel returns the transfer beats in order and then one completion beat
// with final_item set; a failed condition or an unsupported form gives the
// completion beat alone.
// On acceptance the instruction is captured; the first beat is then built
// into the output register from the emit state, and a single transfer
// first passes through an offset state that registers its shifted offset.
// Beats then leave one per cycle from the output register while the
// receiver is ready; a multiple transfer gives one transfer beat for each
// register in its list. A new instruction is taken while the completion
// beat still waits in the output register.
// A stalled receiver holds the current beat and pauses the sequence.
// Reset returns the controller to idle and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module load_store_transfer_sequencer (
	input  logic clk,
	input  logic arst_n,
	lsts_cmd_if.sink    cmd,
	lsts_xfer_if.source xfer
);

	lsts_pkg::dp_cmd_t    dp_cmd;
	lsts_pkg::dp_status_t dp_stat;
	logic                 in_ready;

	lsts_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	lsts_datapath u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (dp_cmd),
		.stat                  (dp_stat),
		.instruction           (cmd.instruction),
		.condition_passed      (cmd.condition_passed),
		.base_value            (cmd.base_value),
		.offset_register_value (cmd.offset_register_value),
		.carry_in              (cmd.carry_in),
		.out_ready             (xfer.ready),
		.out_valid             (xfer.valid),
		.item_kind             (xfer.item_kind),
		.is_load               (xfer.is_load),
		.is_byte               (xfer.is_byte),
		.address               (xfer.address),
		.register_index        (xfer.register_index),
		.writeback_enable      (xfer.writeback_enable),
		.status                (xfer.status),
		.final_item            (xfer.final_item)
	);

	assign cmd.ready = in_ready;

endmodule

`default_nettype wire

### hdl/lsts_checker.sv
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the top-level channels for handshake and sequencing violations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lsts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        item_kind,
	input logic [31:0] address,
	input logic [1:0]  status,
	input logic        final_item
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_addr_stable, clk, arst_n, out_valid && !out_ready, $stable(address))
	`ASSERT_IMP(a_busy_blocks_input, clk, arst_n, out_valid && !final_item, !in_ready)
	`ASSERT_IMP(a_xfer_not_final, clk, arst_n, out_valid && item_kind == lsts_pkg::ITEM_XFER, !final_item && status == lsts_pkg::STATUS_OK)

endmodule

bind load_store_transfer_sequencer lsts_checker u_lsts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (cmd.ready),
	.out_valid  (xfer.valid),
	.out_ready  (xfer.ready),
	.item_kind  (xfer.item_kind),
	.address    (xfer.address),
	.status     (xfer.status),
	.final_item (xfer.final_item)
);

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// Load/store transfer sequencer testbench
// Sends load/store instructions through the cmd channel and checks every
// transfer and completion beat against an in-bench model of the address
// sequence. A short directed table covers the shift forms, the extreme lists
// and the rejected forms; random instructions follow in four idling phases,
// one of them with a long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int DIRECTED_COUNT = 25;
	localparam int PHASE_ITEMS    = 105;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct packed {
		logic [31:0] instruction;
		logic        condition_passed;
		logic [31:0] base_value;
		logic [31:0] offset_register_value;
		logic        carry_in;
	} cmd_word_t;

	typedef struct packed {
		logic        item_kind;
		logic        is_load;
		logic        is_byte;
		logic [31:0] address;
		logic [3:0]  register_index;
		logic        writeback_enable;
		logic [1:0]  status;
		logic        final_item;
	} xfer_beat_t;

	typedef struct packed {
		cmd_word_t  cmd;
		logic       typed;
		xfer_beat_t done;
	} table_row_t;

	localparam xfer_beat_t NO_BEAT = '0;
	localparam xfer_beat_t DONE_COND_FAILED =
		'{lsts_pkg::ITEM_DONE, 1'b0, 1'b0, 32'h0, 4'h0, 1'b0,
			lsts_pkg::STATUS_COND_FAILED, 1'b1};
	localparam xfer_beat_t DONE_UNSUPPORTED =
		'{lsts_pkg::ITEM_DONE, 1'b0, 1'b0, 32'h0, 4'h0, 1'b0,
			lsts_pkg::STATUS_UNSUPPORTED, 1'b1};
	localparam xfer_beat_t DONE_EMPTY_LDM =
		'{lsts_pkg::ITEM_DONE, 1'b1, 1'b0, 32'h00004000, 4'hA, 1'b1,
			lsts_pkg::STATUS_OK, 1'b1};

	logic clk;
	logic arst_n;

	lsts_cmd_if  cmd_bus ();
	lsts_xfer_if xfer_bus ();

	load_store_transfer_sequencer u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_bus),
		.xfer  (xfer_bus)
	);

	table_row_t stimulus_table [DIRECTED_COUNT];
	xfer_beat_t due_beats [$];
	xfer_beat_t seen_beat;
	xfer_beat_t want_beat;
	int         mismatches = 0;
	int         cycle_count = 0;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	int         hold_left = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] shifted_offset(logic [11:0] spec, logic [31:0] rm,
			logic carry);
		logic [4:0] amount;
		amount = spec[11:7];
		case (spec[6:5])
			lsts_pkg::SHIFT_LSL: return rm << amount;
			lsts_pkg::SHIFT_LSR: return (amount == 0) ? 32'h0 : rm >> amount;
			lsts_pkg::SHIFT_ASR: begin
				if (amount == 0) begin
					return {32{rm[31]}};
				end
				return $signed(rm) >>> amount;
			end
			default: begin
				if (amount == 0) begin
					return {carry, rm[31:1]};
				end
				return (rm >> amount) | (rm << (32 - amount));
			end
		endcase
	endfunction

	function automatic xfer_beat_t make_beat(logic kind, logic ld, logic by,
			logic [31:0] addr, logic [3:0] idx, logic wb, logic [1:0] st, logic fin);
		xfer_beat_t b;
		b = '{kind, ld, by, addr, idx, wb, st, fin};
		return b;
	endfunction

	function automatic void queue_beat(xfer_beat_t b);
		due_beats = {due_beats, b};
	endfunction

	function automatic void predict_transfers(cmd_word_t c);
		logic [31:0] ins;
		logic [2:0]  form;
		logic [31:0] off;
		logic [31:0] addr;
		int          r;
		ins  = c.instruction;
		form = ins[27:25];
		if (!c.condition_passed) begin
			queue_beat(DONE_COND_FAILED);
		end else if (form == lsts_pkg::TYPE_SINGLE_IMM ||
				form == lsts_pkg::TYPE_SINGLE_REG) begin
			if (!ins[24] || (ins[25] && ins[4])) begin
				queue_beat(DONE_UNSUPPORTED);
			end else begin
				off  = ins[25] ? shifted_offset(ins[11:0], c.offset_register_value,
					c.carry_in) : {20'h0, ins[11:0]};
				addr = ins[23] ? c.base_value + off : c.base_value - off;
				queue_beat(make_beat(lsts_pkg::ITEM_XFER, ins[20], ins[22], addr,
					ins[15:12], 1'b0, lsts_pkg::STATUS_OK, 1'b0));
				queue_beat(make_beat(lsts_pkg::ITEM_DONE, ins[20], ins[22], addr,
					ins[19:16], ins[21], lsts_pkg::STATUS_OK, 1'b1));
			end
		end else if (form == lsts_pkg::TYPE_MULTIPLE) begin
			addr = c.base_value;
			if (ins[20]) begin
				for (r = 0; r < lsts_pkg::REGISTER_COUNT; r++) begin
					if (ins[r]) begin
						queue_beat(make_beat(lsts_pkg::ITEM_XFER, 1'b1, 1'b0, addr,
							4'(r), 1'b0, lsts_pkg::STATUS_OK, 1'b0));
						addr = addr + lsts_pkg::WORD_STEP;
					end
				end
			end else begin
				for (r = lsts_pkg::REGISTER_COUNT - 1; r >= 0; r--) begin
					if (ins[r]) begin
						addr = addr - lsts_pkg::WORD_STEP;
						queue_beat(make_beat(lsts_pkg::ITEM_XFER, 1'b0, 1'b0, addr,
							4'(r), 1'b0, lsts_pkg::STATUS_OK, 1'b0));
					end
				end
			end
			queue_beat(make_beat(lsts_pkg::ITEM_DONE, ins[20], 1'b0, addr, ins[19:16],
				ins[21], lsts_pkg::STATUS_OK, 1'b1));
		end else begin
			queue_beat(DONE_UNSUPPORTED);
		end
	endfunction

	function automatic cmd_word_t random_cmd();
		cmd_word_t c;
		int        sel;
		sel = $urandom_range(99);
		c.instruction           = $urandom();
		c.condition_passed      = 1'b1;
		c.base_value            = $urandom();
		c.offset_register_value = $urandom();
		c.carry_in              = 1'($urandom_range(1));
		if ($urandom_range(7) == 0) begin
			c.base_value = $urandom_range(1) ? 32'($urandom_range(63)) :
				~32'($urandom_range(63));
		end
		if (sel < 8) begin
			c.condition_passed = 1'b0;
		end else if (sel < 45) begin
			c.instruction[27:26] = 2'b01;
			c.instruction[24]    = 1'b1;
			if (c.instruction[25]) begin
				c.instruction[4] = 1'b0;
			end
		end else if (sel < 82) begin
			c.instruction[27:25] = lsts_pkg::TYPE_MULTIPLE;
			case ($urandom_range(3))
				0: c.instruction[15:0] = 16'($urandom());
				1: c.instruction[15:0] = $urandom_range(1) ? 16'h0 : 16'hFFFF;
				default: c.instruction[15:0] = (16'h1 << $urandom_range(15)) |
					(16'h1 << $urandom_range(15));
			endcase
		end else begin
			c.condition_passed = 1'($urandom_range(1));
		end
		return c;
	endfunction

	task automatic offer(cmd_word_t c, logic typed, xfer_beat_t done);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid                 <= 1'b1;
		cmd_bus.instruction           <= c.instruction;
		cmd_bus.condition_passed      <= c.condition_passed;
		cmd_bus.base_value            <= c.base_value;
		cmd_bus.offset_register_value <= c.offset_register_value;
		cmd_bus.carry_in              <= c.carry_in;
		@(posedge clk);
		while (!cmd_bus.ready) begin
			@(posedge clk);
		end
		if (typed) begin
			queue_beat(done);
		end else begin
			predict_transfers(c);
		end
		@(negedge clk);
	endtask

	task automatic set_phase(int idle_pct, int stall_pct, int hold);
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		hold_left      = hold;
		@(negedge clk);
	endtask

	task automatic note_mismatch(string what, xfer_beat_t want, xfer_beat_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected kind=%0d ld=%0d byte=%0d addr=%h reg=%0d wb=%0d st=%0d fin=%0d",
				what, want.item_kind, want.is_load, want.is_byte, want.address,
				want.register_index, want.writeback_enable, want.status, want.final_item);
			$display("    actual   kind=%0d ld=%0d byte=%0d addr=%h reg=%0d wb=%0d st=%0d fin=%0d",
				got.item_kind, got.is_load, got.is_byte, got.address,
				got.register_index, got.writeback_enable, got.status, got.final_item);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && xfer_bus.valid && xfer_bus.ready) begin
			seen_beat = '{xfer_bus.item_kind, xfer_bus.is_load, xfer_bus.is_byte,
				xfer_bus.address, xfer_bus.register_index, xfer_bus.writeback_enable,
				xfer_bus.status, xfer_bus.final_item};
			if (due_beats.size() == 0) begin
				note_mismatch("unexpected beat", NO_BEAT, seen_beat);
			end else begin
				want_beat = due_beats.pop_front();
				if (seen_beat.item_kind !== want_beat.item_kind ||
						seen_beat.is_load !== want_beat.is_load ||
						seen_beat.is_byte !== want_beat.is_byte ||
						seen_beat.address !== want_beat.address ||
						seen_beat.register_index !== want_beat.register_index ||
						seen_beat.writeback_enable !== want_beat.writeback_enable ||
						seen_beat.status !== want_beat.status ||
						seen_beat.final_item !== want_beat.final_item) begin
					note_mismatch("beat mismatch", want_beat, seen_beat);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[load_store_transfer_sequencer] ERROR");
			$finish;
		end
	end

	initial begin
		xfer_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				xfer_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				xfer_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		arst_n                        = 1'b0;
		cmd_bus.valid                 = 1'b0;
		cmd_bus.instruction           = '0;
		cmd_bus.condition_passed      = 1'b0;
		cmd_bus.base_value            = '0;
		cmd_bus.offset_register_value = '0;
		cmd_bus.carry_in              = 1'b0;
		stimulus_table = '{
			'{'{32'hE5912004, 1'b0, 32'h00001000, 32'h00000000, 1'b0}, 1'b1, DONE_COND_FAILED},
			'{'{32'hE5912004, 1'b1, 32'h00001000, 32'h00000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE5635FFF, 1'b1, 32'h00000000, 32'h00000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE5DFEFFF, 1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b1}, 1'b0, NO_BEAT},
			'{'{32'hE4912004, 1'b1, 32'h00001000, 32'h00000000, 1'b0}, 1'b1, DONE_UNSUPPORTED},
			'{'{32'hE7912314, 1'b1, 32'h00001000, 32'h12345678, 1'b0}, 1'b1, DONE_UNSUPPORTED},
			'{'{32'hE7912003, 1'b1, 32'h80000000, 32'hDEADBEEF, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE7912F83, 1'b1, 32'h00000004, 32'h00000003, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE7912023, 1'b1, 32'h00000100, 32'hFFFFFFFF, 1'b1}, 1'b0, NO_BEAT},
			'{'{32'hE79120A3, 1'b1, 32'h00000100, 32'h80000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE7112043, 1'b1, 32'h00000100, 32'h80000001, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE7912FC3, 1'b1, 32'h00000100, 32'h40000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE7912063, 1'b1, 32'h00000100, 32'h00000003, 1'b1}, 1'b0, NO_BEAT},
			'{'{32'hE7912063, 1'b1, 32'h00000100, 32'h00000003, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE7912463, 1'b1, 32'h00000100, 32'h12345678, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE8BAFFFF, 1'b1, 32'hFFFFFFF0, 32'h00000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE92DFFFF, 1'b1, 32'h00000020, 32'h00000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'hE8BA0000, 1'b1, 32'h00004000, 32'h00000000, 1'b0}, 1'b1, DONE_EMPTY_LDM},
			'{'{32'hE8448001, 1'b1, 32'h00000010, 32'h00000000, 1'b0}, 1'b0, NO_BEAT},
			'{'{32'h00000000, 1'b1, 32'h00000000, 32'h00000000, 1'b0}, 1'b1, DONE_UNSUPPORTED},
			'{'{32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1}, 1'b1, DONE_UNSUPPORTED},
			'{'{32'hEA000000, 1'b1, 32'h00000040, 32'h00000000, 1'b0}, 1'b1, DONE_UNSUPPORTED},
			'{'{32'hEC000000, 1'b1, 32'h00000040, 32'h00000000, 1'b0}, 1'b1, DONE_UNSUPPORTED},
			'{'{32'hE8BAFFFF, 1'b0, 32'h00000040, 32'h00000000, 1'b0}, 1'b1, DONE_COND_FAILED},
			'{'{32'hE7E12F83, 1'b1, 32'hFFFFFFFF, 32'h00000001, 1'b0}, 1'b0, NO_BEAT}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (stimulus_table[i]) begin
			offer(stimulus_table[i].cmd, stimulus_table[i].typed, stimulus_table[i].done);
		end
		// The first random phase opens with a long receiver hold-off.
		set_phase(0, 0, 300);
		repeat (PHASE_ITEMS) offer(random_cmd(), 1'b0, NO_BEAT);
		set_phase(49, 0, 0);
		repeat (PHASE_ITEMS) offer(random_cmd(), 1'b0, NO_BEAT);
		set_phase(0, 49, 0);
		repeat (PHASE_ITEMS) offer(random_cmd(), 1'b0, NO_BEAT);
		set_phase(32, 32, 0);
		repeat (PHASE_ITEMS) offer(random_cmd(), 1'b0, NO_BEAT);
		cmd_bus.valid <= 1'b0;
		while (due_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[load_store_transfer_sequencer] OK");
		end else begin
			$display("[load_store_transfer_sequencer] ERROR");
		end
		$finish;
	end

endmodule

### load_store_transfer_sequencer.f
+incdir+hdl
hdl/lsts_pkg.sv
hdl/lsts_cmd_if.sv
hdl/lsts_xfer_if.sv
hdl/lsts_datapath.sv
hdl/lsts_controller.sv
hdl/load_store_transfer_sequencer.sv
hdl/lsts_checker.sv
test/testbench.sv
